// ----- rtl/lsc_pkg.sv -----
// shared types and constants of the load shedding controller
`timescale 1ns / 1ps

package lsc_pkg;

  localparam int unsigned LoadWidth       = 8;
  localparam int unsigned NumLoadsDefault = 8;
  localparam logic [LoadWidth-1:0] AllLoads = 8'hFF;

  typedef enum logic [1:0] {
    OpPoll   = 2'd0,
    OpExpiry = 2'd1,
    OpButton = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    TmrNone    = 2'd0,
    TmrStart   = 2'd1,
    TmrRestart = 2'd2,
    TmrStop    = 2'd3
  } tmr_cmd_e;

  typedef struct packed {
    logic [LoadWidth-1:0] red_leds;
    logic [LoadWidth-1:0] green_leds;
    logic [LoadWidth-1:0] load_mask;
    logic                 managing;
    logic                 maint_mode;
    tmr_cmd_e             timer_cmd;
    logic                 shed_started;
  } result_t;

endpackage

// ----- rtl/lsc_core.sv -----
// controller state registers and single-pass next-state and result logic
`timescale 1ns / 1ps

module lsc_core import lsc_pkg::*; #(
  parameter int unsigned NUM_LOADS = NumLoadsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           op_i,
  input  logic                 stable_in_i,
  input  logic [LoadWidth-1:0] switches_i,
  output result_t              result_o
);

  localparam int unsigned ActiveCount = (NUM_LOADS >= LoadWidth) ? LoadWidth : NUM_LOADS;
  localparam logic [LoadWidth-1:0] ActiveBits =
    (ActiveCount >= LoadWidth) ? AllLoads : LoadWidth'((64'd1 << ActiveCount) - 64'd1);

  logic                 managing_q, managing_d;
  logic                 stable_q, stable_d;
  logic [LoadWidth-1:0] loads_q, loads_d;
  logic [LoadWidth-1:0] mask_q, mask_d;
  logic                 maint_q, maint_d;

  logic [LoadWidth-1:0] on_act, off_act;
  logic [LoadWidth-1:0] lowest_on, highest_off;
  logic [LoadWidth-1:0] loads_shed, loads_recon, loads_exp;
  tmr_cmd_e             tcmd;
  logic                 started;

  // one-hot of the highest set bit
  function automatic logic [LoadWidth-1:0] highest_bit(input logic [LoadWidth-1:0] v);
    logic [LoadWidth-1:0] pick;
    pick = '0;
    for (int i = 0; i < LoadWidth; i++) begin
      if (v[i]) begin
        pick = LoadWidth'(1) << i;
      end
    end
    return pick;
  endfunction

  assign on_act      = loads_q & ActiveBits;
  assign off_act     = ~loads_q & ActiveBits;
  assign lowest_on   = on_act & (~on_act + LoadWidth'(1));
  assign highest_off = highest_bit(off_act);
  assign loads_shed  = loads_q & ~lowest_on;
  assign loads_recon = loads_q | highest_off;
  assign loads_exp   = stable_q ? loads_recon : loads_shed;

  always_comb begin
    managing_d = managing_q;
    stable_d   = stable_q;
    loads_d    = loads_q;
    mask_d     = mask_q;
    maint_d    = maint_q;
    tcmd       = TmrNone;
    started    = 1'b0;
    unique case (op_i)
      OpPoll: begin
        if (!managing_q) begin
          mask_d = switches_i;
          if (!stable_in_i) begin
            loads_d    = loads_shed;
            tcmd       = TmrStart;
            started    = 1'b1;
            stable_d   = 1'b0;
            managing_d = 1'b1;
          end
        end else begin
          if (stable_in_i != stable_q) begin
            tcmd     = TmrRestart;
            stable_d = stable_in_i;
          end
          mask_d = mask_q & switches_i;
        end
      end
      OpExpiry: begin
        if (managing_q) begin
          loads_d = loads_exp;
          if (loads_exp[0]) begin
            tcmd       = TmrStop;
            managing_d = 1'b0;
          end else begin
            tcmd = TmrRestart;
          end
        end
      end
      OpButton: begin
        maint_d = ~maint_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.load_mask    = loads_d;
    result_o.managing     = managing_d;
    result_o.maint_mode   = maint_d;
    result_o.timer_cmd    = tcmd;
    result_o.shed_started = started;
    if (maint_d) begin
      result_o.red_leds   = switches_i;
      result_o.green_leds = '0;
    end else begin
      result_o.red_leds   = mask_d & ActiveBits;
      result_o.green_leds = ~loads_d & ActiveBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      managing_q <= 1'b0;
      stable_q   <= 1'b1;
      loads_q    <= AllLoads;
      mask_q     <= '0;
      maint_q    <= 1'b0;
    end else if (accept_i) begin
      managing_q <= managing_d;
      stable_q   <= stable_d;
      loads_q    <= loads_d;
      mask_q     <= mask_d;
      maint_q    <= maint_d;
    end
  end

  a_start_enters_manage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.shed_started |-> result_o.managing && result_o.timer_cmd == TmrStart)
    else $error("shed start without entering manage mode");

  a_stop_has_load0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.timer_cmd == TmrStop |-> !result_o.managing && result_o.load_mask[0])
    else $error("timer stop while still managing or load 0 off");

  a_manage_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && result_o.shed_started |=> managing_q && !stable_q)
    else $error("state not updated after shed start");

endmodule

// ----- rtl/lsc_out_buf.sv -----
// result register with skid stage
`timescale 1ns / 1ps

module lsc_out_buf import lsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_data_q, skid_data_q;
  logic    accept, take;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (accept) begin
      skid_data_q <= in_data_i;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data while result register empty");

  a_fill_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && accept |=> skid_valid_q)
    else $error("transaction lost under stall");

  a_drain_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && skid_valid_q |=> out_valid_q && !skid_valid_q)
    else $error("skid not drained into result register");

endmodule

// ----- rtl/load_shedding_controller.sv -----
// top level of the priority load shedding controller
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | op_i, stable_in_i, switches_i
//  out     | output    | out_valid_o/ out_stall_i | red_leds_o, green_leds_o, load_mask_o,
//          |           |                          | managing_o, maint_mode_o, timer_cmd_o,
//          |           |                          | shed_started_o
//
// one event per cycle while in_stall_o is low: the state and the result are computed
// in a single pass, and the result is registered before it shows on the out channel
// a skid stage behind the result register lets one more transaction in while
// the output is stalled; in_stall_o rises only when both stages hold data
// reset puts the block in wait mode, stable, all loads on, switch mask clear
// and maintenance off; no result is pending after reset
`timescale 1ns / 1ps

module load_shedding_controller import lsc_pkg::*; #(
  parameter int unsigned NUM_LOADS = NumLoadsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // event channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic                 stable_in_i,
  input  logic [LoadWidth-1:0] switches_i,
  // status channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LoadWidth-1:0] red_leds_o,
  output logic [LoadWidth-1:0] green_leds_o,
  output logic [LoadWidth-1:0] load_mask_o,
  output logic                 managing_o,
  output logic                 maint_mode_o,
  output logic [1:0]           timer_cmd_o,
  output logic                 shed_started_o
);

  // event transaction taken this cycle
  logic    accept;
  result_t core_res;
  result_t out_res;

  assign accept = in_valid_i && !in_stall_o;

  // mode logic and the shed / reconnect priority encoders
  lsc_core #(
    .NUM_LOADS (NUM_LOADS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .stable_in_i (stable_in_i),
    .switches_i  (switches_i),
    .result_o    (core_res)
  );

  // result register and skid stage
  lsc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (core_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign red_leds_o     = out_res.red_leds;
  assign green_leds_o   = out_res.green_leds;
  assign load_mask_o    = out_res.load_mask;
  assign managing_o     = out_res.managing;
  assign maint_mode_o   = out_res.maint_mode;
  assign timer_cmd_o    = out_res.timer_cmd;
  assign shed_started_o = out_res.shed_started;

endmodule
